[rtl/lmt_pkg.sv]
// Shared types and constants of the latency min/max/mean tracker.
`default_nettype none

package lmt_pkg;

  localparam int unsigned SEC_BITS       = 32;
  localparam int unsigned MICRO_BITS     = 20;
  localparam int unsigned ELAPSED_BITS   = 31;
  localparam int unsigned TOTAL_OUT_BITS = 48;
  localparam int unsigned COUNT_BITS     = 32;
  localparam int unsigned MEAN_BITS      = 39;
  localparam int unsigned MEAN_FRAC      = 8;
  localparam int unsigned US_PER_SEC     = 1000000;

  typedef struct packed {
    logic [SEC_BITS-1:0]   start_seconds;
    logic [MICRO_BITS-1:0] start_micros;
    logic [SEC_BITS-1:0]   stop_seconds;
    logic [MICRO_BITS-1:0] stop_micros;
  } in_item_t;

  typedef struct packed {
    logic [ELAPSED_BITS-1:0]   elapsed_us;
    logic [ELAPSED_BITS-1:0]   min_us;
    logic [ELAPSED_BITS-1:0]   max_us;
    logic [TOTAL_OUT_BITS-1:0] total_us;
    logic [COUNT_BITS-1:0]     sample_count;
    logic [MEAN_BITS-1:0]      mean_q8;
    logic                      clamped;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/lmt_div.sv]
// Restoring bit-serial divider, one quotient bit per cycle.
`default_nettype none

module lmt_div #(
  parameter int unsigned DVD_BITS = 56
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [DVD_BITS-1:0]          dividend,
  input  wire logic [lmt_pkg::COUNT_BITS-1:0] divisor,
  output logic                              done,
  output logic [DVD_BITS-1:0]               quotient
);

  import lmt_pkg::*;

  localparam int unsigned CW = $clog2(DVD_BITS + 1);

  logic [DVD_BITS-1:0]   dvd_r, dvd_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [COUNT_BITS-1:0] dsr_r;
  logic [CW-1:0]         cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [COUNT_BITS:0]   rem_sh;
  logic                  q_bit;

  always_comb begin
    rem_sh = {rem_r, dvd_r[DVD_BITS-1]};
    q_bit  = (rem_sh >= {1'b0, dsr_r});
    if (q_bit) begin
      rem_nxt = COUNT_BITS'(rem_sh - {1'b0, dsr_r});
    end else begin
      rem_nxt = rem_sh[COUNT_BITS-1:0];
    end
    dvd_nxt = {dvd_r[DVD_BITS-2:0], q_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DVD_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && cnt_r == '0)
    else $error("divider done before last step");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && dsr_r != '0 |-> rem_r < dsr_r)
    else $error("partial remainder out of range");

endmodule

`default_nettype wire

[rtl/latency_min_max_mean_tracker_unit.sv]
// Top level of the latency min/max/mean tracker.
// Input channel in_valid/in_ready/in_data carries a start and a stop timestamp
// (seconds plus microseconds). Each transfer yields exactly one result on
// out_valid/out_ready/out_data: the clamped elapsed time in microseconds, the
// running minimum, maximum, saturating total and count, and the mean as
// total*256/count with 8 fraction bits.
// One item at a time: the seconds difference is scaled by one million in the
// multiply state, the sum is clamped, the statistics update, then a bit-serial
// divider computes the mean. The result is then registered in the output
// register, and the next input is taken once the state machine is back in
// idle. The divider's one-bit-per-cycle loop dominates the time per item.
// A finished result waits in the output register while in_ready is already
// high again; a stalled receiver only holds the block once the next result is
// ready and the register is still full.
// Reset (rst_n low, synchronous) empties the pipeline, sets the minimum to all
// ones and the maximum, total and count to zero.
`default_nettype none

module latency_min_max_mean_tracker_unit #(
  parameter int unsigned TOTAL_BITS = 48
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lmt_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lmt_pkg::out_item_t       out_data
);

  import lmt_pkg::*;

  localparam int unsigned DVD_BITS = TOTAL_BITS + MEAN_FRAC;
  localparam int unsigned TSW      = TOTAL_BITS + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_CLP  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]              state_r, state_nxt;
  in_item_t                item_r;
  logic signed [53:0]      prod_r;
  logic [ELAPSED_BITS-1:0] elapsed_r;
  logic                    clamp_r;
  logic [ELAPSED_BITS-1:0] min_r, max_r;
  logic [TOTAL_BITS-1:0]   total_r, total_nxt;
  logic [COUNT_BITS-1:0]   count_r;
  logic                    out_valid_r;
  out_item_t               out_r;

  logic signed [32:0]      sec_diff;
  logic signed [20:0]      usec_k;
  logic signed [53:0]      prod_nxt;
  logic signed [20:0]      us_diff;
  logic signed [54:0]      diff;
  logic [ELAPSED_BITS-1:0] elapsed_nxt;
  logic                    clamp_nxt;
  logic [TSW-1:0]          tsum;
  logic [TOTAL_BITS+TOTAL_OUT_BITS-1:0] total_ext;
  logic [MEAN_BITS-1:0]    mean;
  logic                    out_free;
  logic                    div_start;
  logic                    div_done;
  logic [DVD_BITS-1:0]     quotient;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    sec_diff = $signed({1'b0, item_r.stop_seconds}) - $signed({1'b0, item_r.start_seconds});
    usec_k   = 21'(US_PER_SEC);
    prod_nxt = sec_diff * usec_k;
    us_diff  = $signed({1'b0, item_r.stop_micros}) - $signed({1'b0, item_r.start_micros});
    diff     = 55'(prod_r) + 55'(us_diff);
    if (diff[54]) begin
      elapsed_nxt = '0;
      clamp_nxt   = 1'b1;
    end else if (|diff[53:ELAPSED_BITS]) begin
      elapsed_nxt = '1;
      clamp_nxt   = 1'b1;
    end else begin
      elapsed_nxt = diff[ELAPSED_BITS-1:0];
      clamp_nxt   = 1'b0;
    end
    tsum = {1'b0, total_r} + TSW'(elapsed_r);
    if (tsum[TOTAL_BITS]) begin
      total_nxt = '1;
    end else begin
      total_nxt = tsum[TOTAL_BITS-1:0];
    end
    total_ext = {{TOTAL_OUT_BITS{1'b0}}, total_r};
    if (|quotient[DVD_BITS-1:MEAN_BITS]) begin
      mean = '1;
    end else begin
      mean = quotient[MEAN_BITS-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_CLP;
      S_CLP:  state_nxt = S_UPD;
      S_UPD: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV:  if (div_done) state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  lmt_div #(
    .DVD_BITS (DVD_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({total_nxt, {MEAN_FRAC{1'b0}}}),
    .divisor  (count_r == '1 ? count_r : count_r + 1'b1),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      min_r       <= '1;
      max_r       <= '0;
      total_r     <= '0;
      count_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_UPD) begin
        if (elapsed_r < min_r) min_r <= elapsed_r;
        if (elapsed_r > max_r) max_r <= elapsed_r;
        total_r <= total_nxt;
        if (count_r != '1) count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= in_data;
    if (state_r == S_MUL) prod_r <= prod_nxt;
    if (state_r == S_CLP) begin
      elapsed_r <= elapsed_nxt;
      clamp_r   <= clamp_nxt;
    end
    if (state_r == S_OUT && out_free) begin
      out_r.elapsed_us   <= elapsed_r;
      out_r.min_us       <= min_r;
      out_r.max_us       <= max_r;
      out_r.total_us     <= total_ext[TOTAL_OUT_BITS-1:0];
      out_r.sample_count <= count_r;
      out_r.mean_q8      <= mean;
      out_r.clamped      <= clamp_r;
    end
  end

  a_accept_mul: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_MUL)
    else $error("input transfer did not start the multiply");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 |-> min_r <= max_r)
    else $error("minimum above maximum");

  a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> count_r != '0)
    else $error("result with empty statistics");

endmodule

`default_nettype wire
